@@ design/lxt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lxt_pkg: shared types and constants of the lightmap extent tracker
// Field widths, register indexes, accumulator limits and the structs that
// travel between the front, the queue and the back.
// ----------------------------------------------------------------------------
package lxt_pkg;

  localparam int COORD_W  = 24;  // vertex coordinates and config registers
  localparam int PROD_W   = 48;  // one coordinate times one axis component
  localparam int ACC_W    = 52;  // projected S or T, 24 fraction bits
  localparam int FRAC_W   = 24;
  localparam int LUXEL_SH = 4;   // log2 of the luxel size in texels
  localparam int QUANT_SH = FRAC_W + LUXEL_SH;
  localparam int DIM_W    = 10;
  localparam int MIN_W    = 25;
  localparam int CFG_IDX_W = 3;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [DIM_W-1:0] MAX_DIM = '1;
  localparam logic [MIN_W-1:0] MIN_OUT = 25'h1000000;  // -16777216
  localparam logic [MIN_W-1:0] MAX_OUT = 25'h0FFFFF0;  // 16777200

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  localparam logic [1:0] VCOUNT_SAT = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_S_AXIS_X = 3'd0,
    REG_S_AXIS_Y = 3'd1,
    REG_S_AXIS_Z = 3'd2,
    REG_S_OFFSET = 3'd3,
    REG_T_AXIS_X = 3'd4,
    REG_T_AXIS_Y = 3'd5,
    REG_T_AXIS_Z = 3'd6,
    REG_T_OFFSET = 3'd7
  } lxt_reg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] s_axis_x;
    logic signed [COORD_W-1:0] s_axis_y;
    logic signed [COORD_W-1:0] s_axis_z;
    logic signed [COORD_W-1:0] s_offset;
    logic signed [COORD_W-1:0] t_axis_x;
    logic signed [COORD_W-1:0] t_axis_y;
    logic signed [COORD_W-1:0] t_axis_z;
    logic signed [COORD_W-1:0] t_offset;
  } lxt_cfg_t;

  // one projected vertex
  typedef struct packed {
    logic signed [ACC_W-1:0] s;
    logic signed [ACC_W-1:0] t;
    logic                    last;
  } lxt_proj_t;

  // bounds of a finished polygon
  typedef struct packed {
    logic signed [ACC_W-1:0] s_lo;
    logic signed [ACC_W-1:0] s_hi;
    logic signed [ACC_W-1:0] t_lo;
    logic signed [ACC_W-1:0] t_hi;
    logic                    degen;
  } lxt_extent_t;

endpackage
`default_nettype wire

@@ design/lxt_ifs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lxt_ifs: valid/ready channels of the lightmap extent tracker
// Vertex channel in, extent result channel out.
// ----------------------------------------------------------------------------
interface lxt_vertex_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [lxt_pkg::COORD_W-1:0]   vertex_x;
  logic signed [lxt_pkg::COORD_W-1:0]   vertex_y;
  logic signed [lxt_pkg::COORD_W-1:0]   vertex_z;
  logic                                 last_vertex;

  modport source (output valid, vertex_x, vertex_y, vertex_z, last_vertex, input ready);
  modport sink   (input valid, vertex_x, vertex_y, vertex_z, last_vertex, output ready);
endinterface

interface lxt_result_if;
  logic                                 valid;
  logic                                 ready;
  logic [lxt_pkg::DIM_W-1:0]            luxel_width;
  logic [lxt_pkg::DIM_W-1:0]            luxel_height;
  logic signed [lxt_pkg::MIN_W-1:0]     s_min_aligned;
  logic signed [lxt_pkg::MIN_W-1:0]     t_min_aligned;
  logic                                 size_overflow;

  modport source (output valid, luxel_width, luxel_height, s_min_aligned, t_min_aligned,
                  size_overflow, input ready);
  modport sink   (input valid, luxel_width, luxel_height, s_min_aligned, t_min_aligned,
                  size_overflow, output ready);
endinterface
`default_nettype wire

@@ design/lxt_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lxt_front: vertex projection pipeline
// Three stages: six products, two partial sums per axis, final sum.
// ----------------------------------------------------------------------------
module lxt_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lxt_pkg::lxt_cfg_t cfg,
  lxt_vertex_if.sink             vertex,
  output lxt_pkg::lxt_proj_t     push_data,
  output logic                   push,
  input  wire logic              q_full
);
  import lxt_pkg::*;

  logic v1, v2, v3;
  logic free1, free2, free3;
  logic last1, last2, last3;

  logic signed [PROD_W-1:0] p_sx, p_sy, p_sz, p_tx, p_ty, p_tz;
  logic signed [ACC_W-1:0]  a_s, b_s, a_t, b_t;
  logic signed [ACC_W-1:0]  sum_s, sum_t;
  logic signed [ACC_W-1:0]  off_s, off_t;

  assign free3 = !v3 || !q_full;
  assign free2 = !v2 || free3;
  assign free1 = !v1 || free2;
  assign vertex.ready = free1;

  // offset has 8 fraction bits, the products 24
  assign off_s = {{(ACC_W-COORD_W-16){cfg.s_offset[COORD_W-1]}}, cfg.s_offset, 16'b0};
  assign off_t = {{(ACC_W-COORD_W-16){cfg.t_offset[COORD_W-1]}}, cfg.t_offset, 16'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (free1) v1 <= vertex.valid;
      if (free2) v2 <= v1;
      if (free3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (free1) begin
      p_sx  <= vertex.vertex_x * cfg.s_axis_x;
      p_sy  <= vertex.vertex_y * cfg.s_axis_y;
      p_sz  <= vertex.vertex_z * cfg.s_axis_z;
      p_tx  <= vertex.vertex_x * cfg.t_axis_x;
      p_ty  <= vertex.vertex_y * cfg.t_axis_y;
      p_tz  <= vertex.vertex_z * cfg.t_axis_z;
      last1 <= vertex.last_vertex;
    end
    if (free2) begin
      a_s   <= ACC_W'(p_sx) + ACC_W'(p_sy);
      b_s   <= ACC_W'(p_sz) + off_s;
      a_t   <= ACC_W'(p_tx) + ACC_W'(p_ty);
      b_t   <= ACC_W'(p_tz) + off_t;
      last2 <= last1;
    end
    if (free3) begin
      sum_s <= a_s + b_s;
      sum_t <= a_t + b_t;
      last3 <= last2;
    end
  end

  assign push           = v3 && !q_full;
  assign push_data.s    = sum_s;
  assign push_data.t    = sum_t;
  assign push_data.last = last3;

endmodule
`default_nettype wire

@@ design/lxt_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lxt_queue: short queue of projected vertices
// Decouples the projection pipeline from the bounds tracker.
// ----------------------------------------------------------------------------
module lxt_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire lxt_pkg::lxt_proj_t push_data,
  output logic                    full,
  input  wire logic               pop,
  output lxt_pkg::lxt_proj_t      pop_data,
  output logic                    not_empty
);
  import lxt_pkg::*;

  lxt_proj_t          mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign full      = (count == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule
`default_nettype wire

@@ design/lxt_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lxt_back: bounds tracker and result formatter
// Folds vertices into running min/max, snaps the bounds to luxels.
// ----------------------------------------------------------------------------
module lxt_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_valid,
  input  wire lxt_pkg::lxt_proj_t q_data,
  output logic                    q_pop,
  lxt_result_if.source            result
);
  import lxt_pkg::*;

  logic signed [ACC_W-1:0] s_low, s_high, t_low, t_high;
  logic signed [ACC_W-1:0] s_low_next, s_high_next, t_low_next, t_high_next;
  logic [1:0]              vertex_count;

  lxt_extent_t fin;
  logic        fin_valid;
  logic        out_free, fin_free, fin_adv;

  assign out_free = !result.valid || result.ready;
  assign fin_adv  = fin_valid && out_free;
  assign fin_free = !fin_valid || out_free;
  assign q_pop    = q_valid && (!q_data.last || fin_free);

  assign s_low_next  = (q_data.s < s_low)  ? q_data.s : s_low;
  assign s_high_next = (q_data.s > s_high) ? q_data.s : s_high;
  assign t_low_next  = (q_data.t < t_low)  ? q_data.t : t_low;
  assign t_high_next = (q_data.t > t_high) ? q_data.t : t_high;

  // track bounds; restart on the last vertex
  always_ff @(posedge clk) begin
    if (rst) begin
      s_low        <= ACC_MAX;
      s_high       <= ACC_MIN;
      t_low        <= ACC_MAX;
      t_high       <= ACC_MIN;
      vertex_count <= '0;
      fin_valid    <= 1'b0;
    end else begin
      if (fin_adv) fin_valid <= 1'b0;
      if (q_pop) begin
        if (q_data.last) begin
          s_low        <= ACC_MAX;
          s_high       <= ACC_MIN;
          t_low        <= ACC_MAX;
          t_high       <= ACC_MIN;
          vertex_count <= '0;
          fin_valid    <= 1'b1;
        end else begin
          s_low  <= s_low_next;
          s_high <= s_high_next;
          t_low  <= t_low_next;
          t_high <= t_high_next;
          if (vertex_count != VCOUNT_SAT) vertex_count <= vertex_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_data.last) begin
      fin.s_lo  <= s_low_next;
      fin.s_hi  <= s_high_next;
      fin.t_lo  <= t_low_next;
      fin.t_hi  <= t_high_next;
      fin.degen <= (vertex_count < 2'd2);
    end
  end

  // snap to luxels: floor of the minimum, ceiling of the maximum
  logic signed [COORD_W-1:0] slq, tlq;
  logic signed [COORD_W:0]   shq, thq;
  logic signed [COORD_W+1:0] s_span, t_span;
  logic [DIM_W-1:0]          w_dim, h_dim;
  logic                      w_ovf, h_ovf;
  logic [MIN_W-1:0]          s_min, t_min;

  assign slq = fin.s_lo[ACC_W-1:QUANT_SH];
  assign tlq = fin.t_lo[ACC_W-1:QUANT_SH];
  assign shq = {fin.s_hi[ACC_W-1], fin.s_hi[ACC_W-1:QUANT_SH]}
             + {{COORD_W{1'b0}}, |fin.s_hi[QUANT_SH-1:0]};
  assign thq = {fin.t_hi[ACC_W-1], fin.t_hi[ACC_W-1:QUANT_SH]}
             + {{COORD_W{1'b0}}, |fin.t_hi[QUANT_SH-1:0]};
  assign s_span = {shq[COORD_W], shq} - {{2{slq[COORD_W-1]}}, slq} + 26'sd1;
  assign t_span = {thq[COORD_W], thq} - {{2{tlq[COORD_W-1]}}, tlq} + 26'sd1;

  function automatic logic [DIM_W:0] clamp_dim(input logic [COORD_W+1:0] span);
    logic [DIM_W:0] r;
    if (span[COORD_W+1] || span == '0) begin
      r = {1'b0, {(DIM_W-1){1'b0}}, 1'b1};
    end else if (|span[COORD_W:DIM_W]) begin
      r = {1'b1, MAX_DIM};
    end else begin
      r = {1'b0, span[DIM_W-1:0]};
    end
    return r;
  endfunction

  function automatic logic [MIN_W-1:0] clamp_min(input logic [COORD_W-1:0] q);
    logic [COORD_W+LUXEL_SH-1:0] m;
    logic [MIN_W-1:0]            r;
    m = {q, {LUXEL_SH{1'b0}}};
    if (m[COORD_W+LUXEL_SH-1] && (m[COORD_W+LUXEL_SH-1:MIN_W-1] != '1)) begin
      r = MIN_OUT;
    end else if (!m[COORD_W+LUXEL_SH-1] && (|m[COORD_W+LUXEL_SH-1:MIN_W-1])) begin
      r = MAX_OUT;
    end else begin
      r = m[MIN_W-1:0];
    end
    return r;
  endfunction

  assign {w_ovf, w_dim} = clamp_dim(s_span);
  assign {h_ovf, h_dim} = clamp_dim(t_span);
  assign s_min = clamp_min(slq);
  assign t_min = clamp_min(tlq);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (fin_adv) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_adv) begin
      if (fin.degen) begin
        result.luxel_width   <= '0;
        result.luxel_height  <= '0;
        result.s_min_aligned <= '0;
        result.t_min_aligned <= '0;
        result.size_overflow <= 1'b0;
      end else begin
        result.luxel_width   <= w_dim;
        result.luxel_height  <= h_dim;
        result.s_min_aligned <= s_min;
        result.t_min_aligned <= t_min;
        result.size_overflow <= w_ovf | h_ovf;
      end
    end
  end

endmodule
`default_nettype wire

@@ design/lightmap_extent_tracker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lightmap_extent_tracker: texture-space bounds of a polygon in luxels
// Projects each vertex onto S and T, tracks the bounds, reports the size.
// ----------------------------------------------------------------------------
// Vertices enter one per cycle on the vertex channel while it is ready, the
// last vertex of a polygon flagged. Each vertex is projected onto the S and T
// axes in exact fixed point (24 fraction bits) by a three-stage multiply/add
// pipeline, then passes a four-entry queue into the bounds tracker, which keeps
// the running minimum and maximum of S and T. On the last vertex the bounds are
// snapped to 16-texel luxels and one result item leaves through an output
// register: width, height, aligned minima and an overflow flag; fewer than
// three vertices give an all-zero item. Sustained rate is one vertex per cycle,
// polygons back to back, while the result channel does not stall; a vertex
// passes three projection stages, the queue, bounds and output registers.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// must only change while no vertex is in flight.
// ----------------------------------------------------------------------------
module lightmap_extent_tracker (
  input  wire logic                               clk,
  input  wire logic                               rst,
  lxt_vertex_if.sink                              vertex,
  lxt_result_if.source                            result,
  input  wire logic                               cfg_we,
  input  wire logic [lxt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [lxt_pkg::COORD_W-1:0]        cfg_data
);
  import lxt_pkg::*;

  lxt_cfg_t  cfg;
  lxt_proj_t push_data, pop_data;
  logic      push, pop, q_full, q_valid;

  // configuration registers, reset to zero
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (lxt_reg_t'(cfg_index))
        REG_S_AXIS_X: cfg.s_axis_x <= cfg_data;
        REG_S_AXIS_Y: cfg.s_axis_y <= cfg_data;
        REG_S_AXIS_Z: cfg.s_axis_z <= cfg_data;
        REG_S_OFFSET: cfg.s_offset <= cfg_data;
        REG_T_AXIS_X: cfg.t_axis_x <= cfg_data;
        REG_T_AXIS_Y: cfg.t_axis_y <= cfg_data;
        REG_T_AXIS_Z: cfg.t_axis_z <= cfg_data;
        REG_T_OFFSET: cfg.t_offset <= cfg_data;
        default:      cfg <= cfg;
      endcase
    end
  end

  // project vertices
  lxt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .vertex    (vertex),
    .push_data (push_data),
    .push      (push),
    .q_full    (q_full)
  );

  // buffer projected vertices
  lxt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (q_valid)
  );

  // track bounds and format the result
  lxt_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (pop_data),
    .q_pop   (pop),
    .result  (result)
  );

endmodule
`default_nettype wire
